### rtl/rfb_pkg.sv
// rfb_pkg: types, constants and arithmetic helpers of the radix-6 butterfly.
// Used by every module under rtl; no dependencies.
package rfb_pkg;

    localparam int InW  = 24;               // input field width
    localparam int OutW = 28;               // output field width
    localparam int W    = 32;               // internal half-unit datapath width
    localparam int KW   = 18;               // width of the signed sin(60) constant
    localparam int PW   = W + KW;           // product width
    localparam int RndSh = 17;              // Q1.17 fraction bits
    localparam int Lanes = 2;               // radix-3 groups per item

    localparam logic signed [KW-1:0] Sin60Q17 = 18'sd113512;
    localparam logic signed [PW-1:0] RndHalf  = 50'sd65536;

    typedef enum logic {
        DIR_FWD = 1'b0,
        DIR_INV = 1'b1
    } t_dir;

    typedef logic signed [W-1:0] t_val;

    typedef struct packed {
        t_val re;
        t_val im;
    } t_cpx;

    // [0] = a, [1] = b, [2] = c of one radix-3 group
    typedef t_cpx [2:0] t_grp;
    // two radix-3 groups side by side
    typedef t_grp [Lanes-1:0] t_pair;

    typedef struct packed {
        logic vld;
        t_dir dir;
    } t_side;

    typedef struct packed {
        logic signed [InW-1:0] in0_re;
        logic signed [InW-1:0] in0_im;
        logic signed [InW-1:0] in1_re;
        logic signed [InW-1:0] in1_im;
        logic signed [InW-1:0] in2_re;
        logic signed [InW-1:0] in2_im;
        logic signed [InW-1:0] in3_re;
        logic signed [InW-1:0] in3_im;
        logic signed [InW-1:0] in4_re;
        logic signed [InW-1:0] in4_im;
        logic signed [InW-1:0] in5_re;
        logic signed [InW-1:0] in5_im;
    } t_in_item;

    typedef struct packed {
        logic signed [OutW-1:0] out0_re;
        logic signed [OutW-1:0] out0_im;
        logic signed [OutW-1:0] out1_re;
        logic signed [OutW-1:0] out1_im;
        logic signed [OutW-1:0] out2_re;
        logic signed [OutW-1:0] out2_im;
        logic signed [OutW-1:0] out3_re;
        logic signed [OutW-1:0] out3_im;
        logic signed [OutW-1:0] out4_re;
        logic signed [OutW-1:0] out4_im;
        logic signed [OutW-1:0] out5_re;
        logic signed [OutW-1:0] out5_im;
    } t_out_item;

    // integer to half units
    function automatic t_val to_half(logic signed [InW-1:0] x);
        t_val v;
        v = t_val'(x);
        return v <<< 1;
    endfunction

    function automatic t_cpx cadd(t_cpx a, t_cpx b);
        t_cpx r;
        r.re = a.re + b.re;
        r.im = a.im + b.im;
        return r;
    endfunction

    function automatic t_cpx csub(t_cpx a, t_cpx b);
        t_cpx r;
        r.re = a.re - b.re;
        r.im = a.im - b.im;
        return r;
    endfunction

    // round product to nearest half unit, ties toward plus infinity
    function automatic t_val mul_round(logic signed [PW-1:0] p);
        logic signed [PW-1:0] r;
        r = (p + RndHalf) >>> RndSh;
        return r[W-1:0];
    endfunction

    // half units to nearest integer, ties toward plus infinity
    function automatic logic signed [OutW-1:0] round_out(t_val y);
        t_val h;
        h = (y + t_val'(1)) >>> 1;
        return h[OutW-1:0];
    endfunction

endpackage

### rtl/rfb_pre.sv
// rfb_pre: conversion to half units and the input-side radix-2 step (inverse)
// or point regrouping (forward). Depends on rfb_pkg.
module rfb_pre (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rfb_pkg::t_side    i_side,
    input  rfb_pkg::t_in_item i_item,
    output rfb_pkg::t_side    o_side,
    output rfb_pkg::t_pair    o_pair
);

    rfb_pkg::t_cpx  x [6];
    rfb_pkg::t_pair n_pair;
    rfb_pkg::t_side r_side;
    rfb_pkg::t_pair r_pair;

    always_comb begin
        x[0].re = rfb_pkg::to_half(i_item.in0_re);
        x[0].im = rfb_pkg::to_half(i_item.in0_im);
        x[1].re = rfb_pkg::to_half(i_item.in1_re);
        x[1].im = rfb_pkg::to_half(i_item.in1_im);
        x[2].re = rfb_pkg::to_half(i_item.in2_re);
        x[2].im = rfb_pkg::to_half(i_item.in2_im);
        x[3].re = rfb_pkg::to_half(i_item.in3_re);
        x[3].im = rfb_pkg::to_half(i_item.in3_im);
        x[4].re = rfb_pkg::to_half(i_item.in4_re);
        x[4].im = rfb_pkg::to_half(i_item.in4_im);
        x[5].re = rfb_pkg::to_half(i_item.in5_re);
        x[5].im = rfb_pkg::to_half(i_item.in5_im);
    end

    always_comb begin
        case (i_side.dir)
            rfb_pkg::DIR_INV: begin
                // sums feed one radix-3, differences the other
                n_pair[0][0] = rfb_pkg::cadd(x[0], x[1]);
                n_pair[0][1] = rfb_pkg::cadd(x[3], x[2]);
                n_pair[0][2] = rfb_pkg::cadd(x[4], x[5]);
                n_pair[1][0] = rfb_pkg::csub(x[0], x[1]);
                n_pair[1][1] = rfb_pkg::csub(x[3], x[2]);
                n_pair[1][2] = rfb_pkg::csub(x[4], x[5]);
            end
            default: begin
                n_pair[0][0] = x[0];
                n_pair[0][1] = x[4];
                n_pair[0][2] = x[2];
                n_pair[1][0] = x[3];
                n_pair[1][1] = x[1];
                n_pair[1][2] = x[5];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.vld <= 1'b0;
            r_side.dir <= rfb_pkg::DIR_FWD;
        end else begin
            r_side <= i_side;
        end
        r_pair <= n_pair;
    end

    assign o_side = r_side;
    assign o_pair = r_pair;

endmodule

### rtl/rfb_radix3.sv
// rfb_radix3: two lanes of the twiddle-free radix-3 step in three stages:
// sum/difference, sin(60) product, rounding and combine. Depends on rfb_pkg.
module rfb_radix3 (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rfb_pkg::t_side i_side,
    input  rfb_pkg::t_pair i_pair,
    output rfb_pkg::t_side o_side,
    output rfb_pkg::t_pair o_pair
);

    rfb_pkg::t_cpx n1_t [rfb_pkg::Lanes];
    rfb_pkg::t_cpx n1_m [rfb_pkg::Lanes];
    rfb_pkg::t_cpx n1_d [rfb_pkg::Lanes];
    rfb_pkg::t_pair n3_pair;

    rfb_pkg::t_side r1_side;
    rfb_pkg::t_side r2_side;
    rfb_pkg::t_side r3_side;
    rfb_pkg::t_cpx  r1_t [rfb_pkg::Lanes];
    rfb_pkg::t_cpx  r1_m [rfb_pkg::Lanes];
    rfb_pkg::t_cpx  r1_d [rfb_pkg::Lanes];
    rfb_pkg::t_cpx  r2_t [rfb_pkg::Lanes];
    rfb_pkg::t_cpx  r2_m [rfb_pkg::Lanes];
    logic signed [rfb_pkg::PW-1:0] r2_pr [rfb_pkg::Lanes];
    logic signed [rfb_pkg::PW-1:0] r2_pi [rfb_pkg::Lanes];
    rfb_pkg::t_pair r3_pair;

    // stage 1: t = a+b+c, m = t - 1.5*(b+c) = a - (b+c)/2, d = b-c
    always_comb begin
        rfb_pkg::t_cpx sum;
        for (int l = 0; l < rfb_pkg::Lanes; l++) begin
            sum        = rfb_pkg::cadd(i_pair[l][1], i_pair[l][2]);
            n1_d[l]    = rfb_pkg::csub(i_pair[l][1], i_pair[l][2]);
            n1_t[l]    = rfb_pkg::cadd(i_pair[l][0], sum);
            n1_m[l].re = i_pair[l][0].re - (sum.re >>> 1);
            n1_m[l].im = i_pair[l][0].im - (sum.im >>> 1);
        end
    end

    // stage 3: r1 = m + s*(-j)d, r2 = m - s*(-j)d
    always_comb begin
        rfb_pkg::t_val sr;
        rfb_pkg::t_val si;
        for (int l = 0; l < rfb_pkg::Lanes; l++) begin
            sr = rfb_pkg::mul_round(r2_pr[l]);
            si = rfb_pkg::mul_round(r2_pi[l]);
            n3_pair[l][0]    = r2_t[l];
            n3_pair[l][1].re = r2_m[l].re + si;
            n3_pair[l][1].im = r2_m[l].im - sr;
            n3_pair[l][2].re = r2_m[l].re - si;
            n3_pair[l][2].im = r2_m[l].im + sr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_side.vld <= 1'b0;
            r1_side.dir <= rfb_pkg::DIR_FWD;
            r2_side.vld <= 1'b0;
            r2_side.dir <= rfb_pkg::DIR_FWD;
            r3_side.vld <= 1'b0;
            r3_side.dir <= rfb_pkg::DIR_FWD;
        end else begin
            r1_side <= i_side;
            r2_side <= r1_side;
            r3_side <= r2_side;
        end
        for (int l = 0; l < rfb_pkg::Lanes; l++) begin
            r1_t[l]  <= n1_t[l];
            r1_m[l]  <= n1_m[l];
            r1_d[l]  <= n1_d[l];
            r2_t[l]  <= r1_t[l];
            r2_m[l]  <= r1_m[l];
            r2_pr[l] <= r1_d[l].re * rfb_pkg::Sin60Q17;
            r2_pi[l] <= r1_d[l].im * rfb_pkg::Sin60Q17;
        end
        r3_pair <= n3_pair;
    end

    assign o_side = r3_side;
    assign o_pair = r3_pair;

endmodule

### rtl/rfb_post.sv
// rfb_post: output-side radix-2 step (forward) or slot mapping (inverse),
// final rounding and the output register. Depends on rfb_pkg.
module rfb_post (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rfb_pkg::t_side     i_side,
    input  rfb_pkg::t_pair     i_pair,
    output logic               o_done,
    output rfb_pkg::t_out_item o_result
);

    rfb_pkg::t_cpx      y [6];
    rfb_pkg::t_out_item n_result;
    logic               r_done;
    rfb_pkg::t_out_item r_result;

    always_comb begin
        case (i_side.dir)
            rfb_pkg::DIR_INV: begin
                y[0] = i_pair[0][0];
                y[2] = i_pair[0][1];
                y[4] = i_pair[0][2];
                y[3] = i_pair[1][0];
                y[5] = i_pair[1][1];
                y[1] = i_pair[1][2];
            end
            default: begin
                y[0] = rfb_pkg::cadd(i_pair[0][0], i_pair[1][0]);
                y[1] = rfb_pkg::csub(i_pair[0][0], i_pair[1][0]);
                y[4] = rfb_pkg::cadd(i_pair[0][2], i_pair[1][2]);
                y[5] = rfb_pkg::csub(i_pair[0][2], i_pair[1][2]);
                y[3] = rfb_pkg::cadd(i_pair[0][1], i_pair[1][1]);
                y[2] = rfb_pkg::csub(i_pair[0][1], i_pair[1][1]);
            end
        endcase
    end

    always_comb begin
        n_result.out0_re = rfb_pkg::round_out(y[0].re);
        n_result.out0_im = rfb_pkg::round_out(y[0].im);
        n_result.out1_re = rfb_pkg::round_out(y[1].re);
        n_result.out1_im = rfb_pkg::round_out(y[1].im);
        n_result.out2_re = rfb_pkg::round_out(y[2].re);
        n_result.out2_im = rfb_pkg::round_out(y[2].im);
        n_result.out3_re = rfb_pkg::round_out(y[3].re);
        n_result.out3_im = rfb_pkg::round_out(y[3].im);
        n_result.out4_re = rfb_pkg::round_out(y[4].re);
        n_result.out4_im = rfb_pkg::round_out(y[4].im);
        n_result.out5_re = rfb_pkg::round_out(y[5].re);
        n_result.out5_im = rfb_pkg::round_out(y[5].im);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_side.vld;
        end
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

### rtl/radix6_fft_butterfly_unit.sv
// radix6_fft_butterfly_unit: unscaled radix-6 DFT of six complex points.
// A request taken by the input register moves through six stages (input, pre,
// 3x radix-3, post) before its result is strobed on o_done.
// Throughput: one request per cycle; o_busy is low whenever out of reset.
// Reset (synchronous, active low) clears the pipeline valids and direction.
// Depends on rfb_pkg, rfb_pre, rfb_radix3, rfb_post.
module radix6_fft_butterfly_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  rfb_pkg::t_in_item  i_in,
    output logic               o_done,
    output rfb_pkg::t_out_item o_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data
);

    rfb_pkg::t_dir     r_dir;
    rfb_pkg::t_side    r_s0_side;
    rfb_pkg::t_in_item r_s0_item;
    rfb_pkg::t_side    pre_side;
    rfb_pkg::t_pair    pre_pair;
    rfb_pkg::t_side    r3_side;
    rfb_pkg::t_pair    r3_pair;

    assign o_busy      = ~i_rst_n;
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir         <= rfb_pkg::DIR_FWD;
            r_s0_side.vld <= 1'b0;
            r_s0_side.dir <= rfb_pkg::DIR_FWD;
        end else begin
            if (i_cfg_valid) begin
                r_dir <= rfb_pkg::t_dir'(i_cfg_data);
            end
            r_s0_side.vld <= i_start;
            r_s0_side.dir <= r_dir;
        end
        r_s0_item <= i_in;
    end

    rfb_pre u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (r_s0_side),
        .i_item  (r_s0_item),
        .o_side  (pre_side),
        .o_pair  (pre_pair)
    );

    rfb_radix3 u_radix3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (pre_side),
        .i_pair  (pre_pair),
        .o_side  (r3_side),
        .o_pair  (r3_pair)
    );

    rfb_post u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_side   (r3_side),
        .i_pair   (r3_pair),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // every result strobe traces back to an earlier request on i_start
    a_done_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, 6))
        else $error("result strobe without matching request");

    // slot 0 is the plain sum of all six points in either direction
    a_slot0_re: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.out0_re == $past(28'(i_in.in0_re) + 28'(i_in.in1_re)
            + 28'(i_in.in2_re) + 28'(i_in.in3_re) + 28'(i_in.in4_re)
            + 28'(i_in.in5_re), 6)))
        else $error("slot 0 real part is not the sum of the inputs");

    a_slot0_im: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.out0_im == $past(28'(i_in.in0_im) + 28'(i_in.in1_im)
            + 28'(i_in.in2_im) + 28'(i_in.in3_im) + 28'(i_in.in4_im)
            + 28'(i_in.in5_im), 6)))
        else $error("slot 0 imaginary part is not the sum of the inputs");

endmodule

### tb/sv/tb_radix6_fft_butterfly_unit.sv
// tb_radix6_fft_butterfly_unit: self-checking bench for the radix-6 butterfly unit.
// Drives six-point requests in both directions, predicts each spectrum in-bench.
// Depends on rfb_pkg and radix6_fft_butterfly_unit.
`timescale 1ns / 1ps

module tb_radix6_fft_butterfly_unit;

    localparam int      ItemBits   = 12 * rfb_pkg::InW;
    localparam int      StallLimit = 400;
    localparam int      DrainWait  = 10;
    localparam int      PhaseItems = 250;
    localparam longint  Sin60Q17   = 113512;
    localparam longint  HalfLsbQ17 = 65536;

    typedef struct packed {
        logic signed [63:0] re;
        logic signed [63:0] im;
    } t_cplx;
    typedef t_cplx [2:0] t_trio;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    rfb_pkg::t_in_item  req_item;
    logic               done;
    rfb_pkg::t_out_item result;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_data;

    rfb_pkg::t_out_item expected_spectra[$];
    rfb_pkg::t_dir      fft_dir;
    bit                 req_high;
    bit                 idle_enable;
    int                 err_count;
    int                 spectra_checked;
    int                 fwd_sent;
    int                 inv_sent;
    int                 dir_writes;
    int                 stall_cycles;

    radix6_fft_butterfly_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_in        (req_item),
        .o_done      (done),
        .o_result    (result),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // ---------------- prediction ----------------

    // d * sin(60) in half units, nearest, ties up
    function automatic longint sin60_scale(longint d);
        return (d * Sin60Q17 + HalfLsbQ17) >>> 17;
    endfunction

    function automatic t_cplx cplx_sum(t_cplx a, t_cplx b);
        t_cplx r;
        r.re = a.re + b.re;
        r.im = a.im + b.im;
        return r;
    endfunction

    function automatic t_cplx cplx_diff(t_cplx a, t_cplx b);
        t_cplx r;
        r.re = a.re - b.re;
        r.im = a.im - b.im;
        return r;
    endfunction

    // three-point dft, -1.5 step folded into a - floor(sum/2)
    function automatic t_trio dft3(t_cplx a, t_cplx b, t_cplx c);
        longint sre, sim, dre, dim, mre, mim, kre, kim;
        t_trio  r;
        sre = b.re + c.re;
        sim = b.im + c.im;
        dre = b.re - c.re;
        dim = b.im - c.im;
        mre = a.re - (sre >>> 1);
        mim = a.im - (sim >>> 1);
        kre = sin60_scale(dre);
        kim = sin60_scale(dim);
        r[0].re = a.re + sre;
        r[0].im = a.im + sim;
        r[1].re = mre + kim;
        r[1].im = mim - kre;
        r[2].re = mre - kim;
        r[2].im = mim + kre;
        return r;
    endfunction

    function automatic logic signed [rfb_pkg::OutW-1:0] half_to_int(longint h);
        longint v;
        v = (h + 1) >>> 1;
        return v[rfb_pkg::OutW-1:0];
    endfunction

    function automatic rfb_pkg::t_out_item dft6_expected(rfb_pkg::t_in_item it,
                                                         rfb_pkg::t_dir dir);
        logic [ItemBits-1:0] bits;
        logic signed [rfb_pkg::InW-1:0] f;
        t_cplx     x [6];
        t_cplx     y [6];
        t_trio     g0, g1;
        rfb_pkg::t_out_item r;
        bits = it;
        for (int k = 0; k < 6; k++) begin
            f = bits[ItemBits-1-48*k -: rfb_pkg::InW];
            x[k].re = 2 * longint'(f);
            f = bits[ItemBits-1-48*k-rfb_pkg::InW -: rfb_pkg::InW];
            x[k].im = 2 * longint'(f);
        end
        if (dir == rfb_pkg::DIR_FWD) begin
            g0 = dft3(x[0], x[4], x[2]);
            g1 = dft3(x[3], x[1], x[5]);
            y[0] = cplx_sum(g0[0], g1[0]);
            y[1] = cplx_diff(g0[0], g1[0]);
            y[4] = cplx_sum(g0[2], g1[2]);
            y[5] = cplx_diff(g0[2], g1[2]);
            y[3] = cplx_sum(g0[1], g1[1]);
            y[2] = cplx_diff(g0[1], g1[1]);
        end else begin
            g0 = dft3(cplx_sum(x[0], x[1]), cplx_sum(x[3], x[2]),
                      cplx_sum(x[4], x[5]));
            g1 = dft3(cplx_diff(x[0], x[1]), cplx_diff(x[3], x[2]),
                      cplx_diff(x[4], x[5]));
            y[0] = g0[0];
            y[2] = g0[1];
            y[4] = g0[2];
            y[3] = g1[0];
            y[5] = g1[1];
            y[1] = g1[2];
        end
        r.out0_re = half_to_int(y[0].re);
        r.out0_im = half_to_int(y[0].im);
        r.out1_re = half_to_int(y[1].re);
        r.out1_im = half_to_int(y[1].im);
        r.out2_re = half_to_int(y[2].re);
        r.out2_im = half_to_int(y[2].im);
        r.out3_re = half_to_int(y[3].re);
        r.out3_im = half_to_int(y[3].im);
        r.out4_re = half_to_int(y[4].re);
        r.out4_im = half_to_int(y[4].im);
        r.out5_re = half_to_int(y[5].re);
        r.out5_im = half_to_int(y[5].im);
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    // one point set to (re, im), the others to (rest_re, rest_im)
    function automatic rfb_pkg::t_in_item point_item(int k,
                                                     logic [rfb_pkg::InW-1:0] re,
                                                     logic [rfb_pkg::InW-1:0] im,
                                                     logic [rfb_pkg::InW-1:0] rest_re,
                                                     logic [rfb_pkg::InW-1:0] rest_im);
        logic [ItemBits-1:0] bits;
        for (int p = 0; p < 6; p++) begin
            bits[ItemBits-1-48*p -: rfb_pkg::InW] = (p == k) ? re : rest_re;
            bits[ItemBits-1-48*p-rfb_pkg::InW -: rfb_pkg::InW] = (p == k) ? im : rest_im;
        end
        return rfb_pkg::t_in_item'(bits);
    endfunction

    function automatic logic [rfb_pkg::InW-1:0] rand_field();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(7))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return rfb_pkg::InW'($signed(raw[3:0]));
            default: return raw[rfb_pkg::InW-1:0];
        endcase
    endfunction

    function automatic rfb_pkg::t_in_item rand_item();
        logic [ItemBits-1:0] bits;
        for (int f = 0; f < 12; f++)
            bits[ItemBits-1-rfb_pkg::InW*f -: rfb_pkg::InW] = rand_field();
        return rfb_pkg::t_in_item'(bits);
    endfunction

    task automatic send_request(input rfb_pkg::t_in_item it);
        while (idle_enable && $urandom_range(99) < 33) begin
            if (req_high) begin
                start <= 1'b0;
                req_high = 1'b0;
            end
            @(posedge clk);
        end
        if (!req_high) begin
            start <= 1'b1;
            req_high = 1'b1;
        end
        req_item <= it;
        @(posedge clk);
        while (busy) @(posedge clk);
        expected_spectra.push_back(dft6_expected(it, fft_dir));
        if (fft_dir == rfb_pkg::DIR_FWD) fwd_sent++;
        else inv_sent++;
    endtask

    task automatic drain_requests();
        if (req_high) begin
            start <= 1'b0;
            req_high = 1'b0;
        end
        while (expected_spectra.size() != 0) @(posedge clk);
    endtask

    task automatic write_direction(input rfb_pkg::t_dir d);
        drain_requests();
        cfg_valid <= 1'b1;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        fft_dir = d;
        dir_writes++;
    endtask

    // ---------------- tests ----------------

    // zeros, full-scale points, each point alone, sin60 rounding ties
    task automatic test_directed_set();
        send_request(point_item(0, '0, '0, '0, '0));
        send_request(point_item(0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
        send_request(point_item(0, 24'h800000, 24'h800000, 24'h800000, 24'h800000));
        send_request(point_item(0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
        send_request(point_item(2, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF));
        for (int k = 0; k < 6; k++)
            send_request(point_item(k, 24'h7FFFFF, 24'h800000, '0, '0));
        // b - c of 4096 lands exactly halfway in the sin60 product
        send_request(point_item(4, 24'd4096, -24'sd4096, '0, '0));
        send_request(point_item(4, 24'd12288, -24'sd12288, 24'd1, 24'hFFFFFF));
    endtask

    task automatic test_forward_after_reset();
        test_directed_set();
    endtask

    task automatic test_inverse_directed();
        write_direction(rfb_pkg::DIR_INV);
        test_directed_set();
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 6; ph++) begin
            write_direction(ph % 2 ? rfb_pkg::DIR_INV : rfb_pkg::DIR_FWD);
            idle_enable = (ph != 2);
            for (int n = 0; n < PhaseItems; n++)
                send_request(rand_item());
        end
        idle_enable = 1'b1;
    endtask

    // ---------------- result checking ----------------

    task automatic check_field(input string name,
                               input logic signed [rfb_pkg::OutW-1:0] want,
                               input logic signed [rfb_pkg::OutW-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge clk) begin
        rfb_pkg::t_out_item want;
        if (rst_n && done) begin
            if (expected_spectra.size() == 0) begin
                $error("result strobed with no request pending");
                err_count++;
            end else begin
                want = expected_spectra.pop_front();
                check_field("out0_re", want.out0_re, result.out0_re);
                check_field("out0_im", want.out0_im, result.out0_im);
                check_field("out1_re", want.out1_re, result.out1_re);
                check_field("out1_im", want.out1_im, result.out1_im);
                check_field("out2_re", want.out2_re, result.out2_re);
                check_field("out2_im", want.out2_im, result.out2_im);
                check_field("out3_re", want.out3_re, result.out3_re);
                check_field("out3_im", want.out3_im, result.out3_im);
                check_field("out4_re", want.out4_re, result.out4_re);
                check_field("out4_im", want.out4_im, result.out4_im);
                check_field("out5_re", want.out5_re, result.out5_re);
                check_field("out5_im", want.out5_im, result.out5_im);
                spectra_checked++;
            end
        end
    end

    // watchdog on cycles where no request, result or config write moves
    always @(posedge clk) begin
        if ((rst_n && start && !busy) || (rst_n && done) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= StallLimit) begin
            $display("timeout after %0d idle cycles", stall_cycles);
            $display("tb_radix6_fft_butterfly_unit: errors");
            $finish;
        end
    end

    initial begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        start           = 1'b0;
        req_item        = '0;
        cfg_valid       = 1'b0;
        cfg_data        = 1'b0;
        fft_dir         = rfb_pkg::DIR_FWD;
        req_high        = 1'b0;
        idle_enable     = 1'b1;
        err_count       = 0;
        spectra_checked = 0;
        fwd_sent        = 0;
        inv_sent        = 0;
        dir_writes      = 0;
        stall_cycles    = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_forward_after_reset();
        test_inverse_directed();
        test_random_phases();

        drain_requests();
        repeat (DrainWait) @(posedge clk);
        $display("checked %0d spectra: %0d forward, %0d inverse requests",
                 spectra_checked, fwd_sent, inv_sent);
        $display("direction register written %0d times, both settings", dir_writes);
        if (err_count == 0 && expected_spectra.size() == 0)
            $display("tb_radix6_fft_butterfly_unit: clean");
        else
            $display("tb_radix6_fft_butterfly_unit: errors");
        $finish;
    end

endmodule

### files.f
rtl/rfb_pkg.sv
rtl/rfb_pre.sv
rtl/rfb_radix3.sv
rtl/rfb_post.sv
rtl/radix6_fft_butterfly_unit.sv
tb/sv/tb_radix6_fft_butterfly_unit.sv
